// ===== design/gpio_port_register_block_top_assert.svh =====
// Assertion macros shared by the GPIO port register block checkers.
// Standalone header; no dependencies.
`ifndef GPIO_PORT_REGISTER_BLOCK_TOP_ASSERT_SVH
`define GPIO_PORT_REGISTER_BLOCK_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define GPB_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("gpb assertion failed");

// Next-cycle implication, disabled during reset.
`define GPB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("gpb assertion failed");

`endif

// ===== design/gpb_pkg.sv =====
// Shared types, register codes and helpers for the GPIO port register block.
// No dependencies.
package gpb_pkg;

   localparam int unsigned PIN_COUNT_DEFAULT = 16;
   localparam int unsigned PIN_W       = 16;
   localparam int unsigned DATA_W      = 32;
   localparam int unsigned SEL_W       = 3;
   localparam int unsigned REQ_TDATA_W = 48;
   localparam int unsigned REQ_TUSER_W = 4;
   localparam int unsigned RSP_TDATA_W = 56;

   localparam logic [DATA_W-1:0] CFG_RESET = 32'h4444_4444;

   // access kind
   localparam logic KIND_READ  = 1'b0;
   localparam logic KIND_WRITE = 1'b1;

   // register select codes
   localparam logic [SEL_W-1:0] SEL_CFG_LOW  = 3'd0;
   localparam logic [SEL_W-1:0] SEL_CFG_HIGH = 3'd1;
   localparam logic [SEL_W-1:0] SEL_INPUT    = 3'd2;
   localparam logic [SEL_W-1:0] SEL_OUTPUT   = 3'd3;
   localparam logic [SEL_W-1:0] SEL_SET_RST  = 3'd4;
   localparam logic [SEL_W-1:0] SEL_RESET    = 3'd5;
   localparam logic [SEL_W-1:0] SEL_LOCK     = 3'd6;

   typedef struct packed {
      logic              kind;
      logic [SEL_W-1:0]  reg_sel;
      logic [DATA_W-1:0] write_data;
      logic [PIN_W-1:0]  pin_levels;
   } req_item_type;

   typedef struct packed {
      logic [DATA_W-1:0] read_data;
      logic [PIN_W-1:0]  output_levels;
      logic              locked;
      logic              bad_access;
   } rsp_item_type;

   // Merge a config write into one word of eight 4-bit pin fields.
   // hi_word picks pins 8-15; fields of absent or frozen pins keep old.
   function automatic logic [DATA_W-1:0] cfg_merge(
      input logic [DATA_W-1:0] old_word,
      input logic [DATA_W-1:0] data,
      input logic              hi_word,
      input logic              key,
      input logic [PIN_W-1:0]  lock_mask,
      input logic [PIN_W-1:0]  pin_mask
   );
      logic [DATA_W-1:0] res;
      logic [3:0]        pin;
      res = old_word;
      for (int i = 0; i < 8; i++) begin
         pin = {hi_word, 3'(i)};
         if (pin_mask[pin] && !(key && lock_mask[pin])) begin
            res[4*i +: 4] = data[4*i +: 4];
         end
      end
      return res;
   endfunction

endpackage

// ===== design/gpb_in_stage.sv =====
// Input register of the GPIO port register block: holds one accepted item.
// Depends on gpb_pkg.
module gpb_in_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  gpb_pkg::req_item_type in_item,
   input  logic                 advance,
   output logic                 held_valid,
   output gpb_pkg::req_item_type held_item
);
   import gpb_pkg::*;

   logic         valid_ff, valid_in;
   req_item_type item_ff;

   assign in_ready = !valid_ff || advance;

   always_comb begin
      if (in_valid && in_ready) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         item_ff <= in_item;
      end
   end

   assign held_valid = valid_ff;
   assign held_item  = item_ff;

endmodule

// ===== design/gpb_core.sv =====
// Register file and access logic of the GPIO port: config words, output
// latch and lock sequencer. Depends on gpb_pkg.
module gpb_core #(
   parameter int unsigned PIN_COUNT = gpb_pkg::PIN_COUNT_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  fire,
   input  gpb_pkg::req_item_type item,
   output gpb_pkg::rsp_item_type result
);
   import gpb_pkg::*;

   localparam logic [1:0] LOCK_IDLE = 2'd0;
   localparam logic [1:0] LOCK_ONE  = 2'd1;
   localparam logic [1:0] LOCK_TWO  = 2'd2;

   logic [DATA_W-1:0] cfg_low_ff, cfg_low_in;
   logic [DATA_W-1:0] cfg_high_ff, cfg_high_in;
   logic [PIN_W-1:0]  out_latch_ff, out_latch_in;
   logic [PIN_W-1:0]  lock_mask_ff, lock_mask_in;
   logic              lock_key_ff, lock_key_in;
   logic [1:0]        lock_step_ff, lock_step_in;

   logic [PIN_W-1:0]  pin_mask;
   logic [PIN_W-1:0]  wr_lo;
   logic [PIN_W-1:0]  wr_hi;
   logic              key_bit;
   logic              same_mask;
   logic [DATA_W-1:0] rd;
   logic              bad;

   always_comb begin
      for (int i = 0; i < PIN_W; i++) begin
         pin_mask[i] = (i < PIN_COUNT);
      end
   end

   assign wr_lo     = item.write_data[PIN_W-1:0];
   assign wr_hi     = item.write_data[2*PIN_W-1:PIN_W];
   assign key_bit   = item.write_data[PIN_W];
   assign same_mask = (wr_lo & pin_mask) == lock_mask_ff;

   always_comb begin
      cfg_low_in   = cfg_low_ff;
      cfg_high_in  = cfg_high_ff;
      out_latch_in = out_latch_ff;
      lock_mask_in = lock_mask_ff;
      lock_key_in  = lock_key_ff;
      lock_step_in = lock_step_ff;
      rd           = '0;
      bad          = 1'b0;
      if (item.kind == KIND_READ) begin
         unique case (item.reg_sel)
            SEL_CFG_LOW:  rd = cfg_low_ff;
            SEL_CFG_HIGH: rd = cfg_high_ff;
            SEL_INPUT:    rd = {{(DATA_W-PIN_W){1'b0}}, item.pin_levels & pin_mask};
            SEL_OUTPUT:   rd = {{(DATA_W-PIN_W){1'b0}}, out_latch_ff};
            SEL_LOCK:     rd = {{(DATA_W-PIN_W-1){1'b0}}, lock_key_ff, lock_mask_ff};
            default:      rd = '0;   // write-only and unused selects
         endcase
      end else begin
         unique case (item.reg_sel)
            SEL_CFG_LOW: cfg_low_in = cfg_merge(cfg_low_ff, item.write_data, 1'b0,
                                                lock_key_ff, lock_mask_ff, pin_mask);
            SEL_CFG_HIGH: cfg_high_in = cfg_merge(cfg_high_ff, item.write_data, 1'b1,
                                                  lock_key_ff, lock_mask_ff, pin_mask);
            SEL_INPUT:   bad = 1'b1;
            SEL_OUTPUT:  out_latch_in = wr_lo & pin_mask;
            // set wins over reset for the same pin
            SEL_SET_RST: out_latch_in = ((out_latch_ff & ~wr_hi) | wr_lo) & pin_mask;
            SEL_RESET:   out_latch_in = out_latch_ff & ~wr_lo & pin_mask;
            SEL_LOCK: begin
               if (!lock_key_ff) begin
                  lock_mask_in = wr_lo & pin_mask;
                  if (lock_step_ff == LOCK_ONE && !key_bit && same_mask) begin
                     lock_step_in = LOCK_TWO;
                  end else if (lock_step_ff == LOCK_TWO && key_bit && same_mask) begin
                     lock_key_in  = 1'b1;
                     lock_step_in = LOCK_IDLE;
                  end else begin
                     lock_step_in = key_bit ? LOCK_ONE : LOCK_IDLE;
                  end
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_low_ff   <= CFG_RESET;
         cfg_high_ff  <= CFG_RESET;
         out_latch_ff <= '0;
         lock_mask_ff <= '0;
         lock_key_ff  <= 1'b0;
         lock_step_ff <= LOCK_IDLE;
      end else if (fire) begin
         cfg_low_ff   <= cfg_low_in;
         cfg_high_ff  <= cfg_high_in;
         out_latch_ff <= out_latch_in;
         lock_mask_ff <= lock_mask_in;
         lock_key_ff  <= lock_key_in;
         lock_step_ff <= lock_step_in;
      end
   end

   assign result.read_data     = rd;
   assign result.output_levels = out_latch_in;
   assign result.locked        = lock_key_in;
   assign result.bad_access    = bad;

endmodule

// ===== design/gpb_out_stage.sv =====
// Result register of the GPIO port register block.
// Depends on gpb_pkg.
module gpb_out_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  gpb_pkg::rsp_item_type load_item,
   output logic                  free,
   output logic                  out_valid,
   input  logic                  out_ready,
   output gpb_pkg::rsp_item_type out_item
);
   import gpb_pkg::*;

   logic         valid_ff, valid_in;
   rsp_item_type item_ff;

   assign free = !valid_ff || out_ready;

   always_comb begin
      if (load) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= load_item;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

// ===== design/gpio_port_register_block_top.sv =====
// Top level of the GPIO port register block: input register, access logic,
// result register. Depends on gpb_pkg, gpb_in_stage, gpb_core, gpb_out_stage.
//
//   channel | dir | tdata (low bit up)                          | tuser
//   req     | in  | write_data[31:0], pin_levels[47:32]         | kind[0], reg_sel[3:1]
//   rsp     | out | read_data[31:0], output_levels[47:32],      | -
//           |     | locked[48], bad_access[49], zero[55:50]     |
//
// One item per cycle sustained while rsp_tready is high; an item's result shows on
// rsp_tvalid once it has passed from acceptance through the input register and
// then the result register.
// The register file is updated as the item moves from the input register into
// the result register, so back-to-back accesses see each other's writes.
// A stalled result holds both registers; req_tready drops only when both are
// full and rsp_tready is low.
// Synchronous reset restores config words to 0x44444444, clears latch and lock.
module gpio_port_register_block_top #(
   parameter int unsigned PIN_COUNT = gpb_pkg::PIN_COUNT_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // write_data[31:0], pin_levels[47:32]
   input  logic [gpb_pkg::REQ_TDATA_W-1:0] req_tdata,
   // kind[0], reg_sel[3:1]
   input  logic [gpb_pkg::REQ_TUSER_W-1:0] req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // read_data[31:0], output_levels[47:32], locked[48], bad_access[49]
   output logic [gpb_pkg::RSP_TDATA_W-1:0] rsp_tdata
);
   import gpb_pkg::*;

   req_item_type req_item;
   req_item_type held_item;
   rsp_item_type core_result;
   rsp_item_type rsp_item;
   logic         held_valid;
   logic         out_free;
   logic         fire;

   assign req_item.kind       = req_tuser[0];
   assign req_item.reg_sel    = req_tuser[SEL_W:1];
   assign req_item.write_data = req_tdata[DATA_W-1:0];
   assign req_item.pin_levels = req_tdata[DATA_W+PIN_W-1:DATA_W];

   // item moves from input register to result register this cycle
   assign fire = held_valid && out_free;

   gpb_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_item    (req_item),
      .advance    (out_free),
      .held_valid (held_valid),
      .held_item  (held_item)
   );

   gpb_core #(
      .PIN_COUNT (PIN_COUNT)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .item   (held_item),
      .result (core_result)
   );

   gpb_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .load      (fire),
      .load_item (core_result),
      .free      (out_free),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_item  (rsp_item)
   );

   assign rsp_tdata = {{(RSP_TDATA_W-DATA_W-PIN_W-2){1'b0}},
                       rsp_item.bad_access, rsp_item.locked,
                       rsp_item.output_levels, rsp_item.read_data};

endmodule

// ===== design/gpb_checker.sv =====
// Port-level checks for the GPIO port register block, bound to the top level.
// Depends on gpb_pkg and gpio_port_register_block_top_assert.svh.
`include "gpio_port_register_block_top_assert.svh"

module gpb_port_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [gpb_pkg::RSP_TDATA_W-1:0] rsp_tdata
);
   import gpb_pkg::*;

   logic rsp_locked;
   logic rsp_bad;

   assign rsp_locked = rsp_tdata[DATA_W+PIN_W];
   assign rsp_bad    = rsp_tdata[DATA_W+PIN_W+1];

   // a rejected write never returns read data
   `GPB_ASSERT_NOW(a_bad_reads_zero, clock, reset, rsp_tvalid && rsp_bad,
                   rsp_tdata[DATA_W-1:0] == '0)

   // the lock is sticky until reset
   `GPB_ASSERT_NEXT(a_lock_sticky, clock, reset, rsp_tvalid && rsp_locked,
                    !rsp_tvalid || rsp_locked)

   // no result straight out of reset
   `GPB_ASSERT_NOW(a_reset_empty, clock, reset, $past(reset), !rsp_tvalid)

   // a stalled result holds
   `GPB_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
                    rsp_tvalid && $stable(rsp_tdata))

   // with the result side taking items, the block always takes an item
   `GPB_ASSERT_NOW(a_no_bubble, clock, reset, req_tvalid && rsp_tready,
                   req_tready)

endmodule

bind gpio_port_register_block_top gpb_port_checker u_gpb_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
